// ----- design/starfield_star_step_core_assert.svh -----
// Assertion macros for the starfield star step core.
`ifndef STARFIELD_STAR_STEP_CORE_ASSERT_SVH
`define STARFIELD_STAR_STEP_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define SFSS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfss check failed");

`define SFSS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfss check failed");

`else

`define SFSS_ASSERT_IMP(lbl, ante, cons)

`define SFSS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- design/sfss_pkg.sv -----
// Shared types and constants for the starfield star step core.
package sfss_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int DEPTH_MAX     = 256;
    localparam int MID_COL       = SCREEN_WIDTH / 2;
    localparam int MID_ROW       = SCREEN_HEIGHT / 2;
    localparam int PROJ_SHIFT    = 7;
    localparam int GRAY_BASE     = 256;
    localparam int STREAK_MUL    = 18;
    localparam int PIXEL_MUL     = 20;
    localparam int BOX_MUL       = 8;

    localparam logic [5:0] SPEED_RESET = 6'd7;

    // |offset| * 128 needs 16 bits; depth up to 511 needs 9
    localparam int DIV_NUM_W = 16;
    localparam int DIV_DEN_W = 9;

    typedef enum logic [1:0] {
        SHAPE_PIXEL  = 2'd0,
        SHAPE_BOX    = 2'd1,
        SHAPE_CIRCLE = 2'd2
    } shape_t;

    typedef struct packed {
        logic signed [8:0] star_x;
        logic signed [7:0] star_y;
        logic [8:0]        star_z;
        logic [8:0]        rand_x;
        logic [7:0]        rand_y;
    } sfss_in_t;

    typedef struct packed {
        logic signed [8:0] next_x;
        logic signed [7:0] next_y;
        logic [8:0]        next_z;
        logic              visible;
        logic [8:0]        plot_x;
        logic [7:0]        plot_y;
        logic [7:0]        gray;
        logic [1:0]        mark_shape;
        logic              streak;
        logic [8:0]        streak_x;
        logic [7:0]        streak_y;
        logic [6:0]        streak_gray;
    } sfss_out_t;

    // per-star data that rides alongside the dividers
    typedef struct packed {
        logic signed [8:0] next_x;
        logic signed [7:0] next_y;
        logic [8:0]        next_z;
        logic              x_neg;
        logic              y_neg;
        logic              streak_ok;
        shape_t            shape;
        logic [7:0]        gray;
        logic [6:0]        sgray;
    } sfss_side_t;

endpackage

// ----- design/starfield_star_step_core.sv -----
// Starfield star step: move, respawn and project one star per cycle unless stalled.
//
//   channel  handshake            payload      width
//   in       in_valid / in_ready  sfss_in_t    43
//   out      out_valid/out_ready  sfss_out_t   79
//   cfg      cfg_we               cfg_wdata    6 (speed)
//
// One request per cycle unless back-pressure drops in_ready; a request
// passes 19 register stages: two front stages, 16 divider stages (one
// quotient bit each), one output register. Each stage holds while the one
// after it is full and stalled, so bubbles fill and in_ready drops only when
// all are full. Reset clears every valid bit and loads speed with 7.
module starfield_star_step_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sfss_pkg::sfss_in_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output sfss_pkg::sfss_out_t out_data,
    input  logic             cfg_we,
    input  logic [5:0]       cfg_wdata
);

    import sfss_pkg::*;

    `include "starfield_star_step_core_assert.svh"

    localparam int DIV_FIRST = 2;
    localparam int NSTG      = DIV_NUM_W + 3;
    localparam int OUT_STG   = NSTG - 1;
    localparam int POS_W     = DIV_NUM_W + 2;

    logic [5:0]      speed_reg;
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] stage_en;

    // stage 0: move / respawn
    logic signed [10:0] z_diff;
    logic               respawn;
    logic [8:0]         rx_mod;
    logic [7:0]         ry_mod;
    logic signed [9:0]  x_spawn;
    logic signed [8:0]  y_spawn;
    logic signed [8:0]  s1_x_next, s1_x_reg;
    logic signed [7:0]  s1_y_next, s1_y_reg;
    logic [8:0]         s1_z_next, s1_z_reg;

    // stage 1: divider operands and depth-derived fields
    logic [8:0]          ax;
    logic [7:0]          ay;
    logic [9:0]          pz_sum;
    logic [10:0]         z_ext, thr_streak, thr_pixel, thr_box;
    logic signed [9:0]   gray_diff, gray_adj;
    logic [DIV_NUM_W-1:0] s2_num_x_next, s2_num_x_reg;
    logic [DIV_NUM_W-1:0] s2_num_y_next, s2_num_y_reg;
    logic [DIV_DEN_W-1:0] s2_pz_next, s2_pz_reg;
    sfss_side_t          s2_side_next, s2_side_reg;

    // divider stages
    sfss_side_t          side_reg [DIV_NUM_W];
    logic [DIV_NUM_W-1:0] q_x, q_y, q_px, q_py;

    // output stage
    sfss_side_t          side_last;
    logic signed [POS_W-1:0] sx, sy, px, py;
    logic                vis, streak_hit;
    sfss_out_t           out_next, out_reg;

    function automatic logic signed [POS_W-1:0] place(
        input logic [DIV_NUM_W-1:0] q,
        input logic                 neg,
        input int                   center
    );
        logic signed [POS_W-1:0] c;
        logic signed [POS_W-1:0] m;
        c = POS_W'(center);
        m = $signed({2'b00, q});
        return neg ? (c - m) : (c + m);
    endfunction

    function automatic logic on_axis(
        input logic signed [POS_W-1:0] pos,
        input int                      limit
    );
        return !pos[POS_W-1] && ($unsigned(pos) < POS_W'(limit));
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            speed_reg <= SPEED_RESET;
        else if (cfg_we)
            speed_reg <= cfg_wdata;
    end

    // a stage may load when the sink is ready or it or any stage after it has room
    for (genvar i = 0; i < NSTG; i++)
    begin : g_en
        assign stage_en[i] = out_ready | ~(&valid_reg[NSTG-1:i]);
    end

    assign in_ready = stage_en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (stage_en[0])
                valid_reg[0] <= in_valid;
            for (int i = 1; i < NSTG; i++)
            begin
                if (stage_en[i])
                    valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_comb
    begin
        z_diff  = $signed({2'b00, in_data.star_z}) - $signed({5'b00000, speed_reg});
        respawn = z_diff[10] || (z_diff == '0);
        rx_mod  = (in_data.rand_x >= 9'(SCREEN_WIDTH)) ?
                  (in_data.rand_x - 9'(SCREEN_WIDTH)) : in_data.rand_x;
        ry_mod  = (in_data.rand_y >= 8'(SCREEN_HEIGHT)) ?
                  (in_data.rand_y - 8'(SCREEN_HEIGHT)) : in_data.rand_y;
        x_spawn = $signed({1'b0, rx_mod}) - $signed(10'(MID_COL));
        y_spawn = $signed({1'b0, ry_mod}) - $signed(9'(MID_ROW));
        s1_x_next = respawn ? x_spawn[8:0] : in_data.star_x;
        s1_y_next = respawn ? y_spawn[7:0] : in_data.star_y;
        s1_z_next = respawn ? 9'(DEPTH_MAX) : z_diff[8:0];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s1_x_reg <= s1_x_next;
            s1_y_reg <= s1_y_next;
            s1_z_reg <= s1_z_next;
        end
    end

    always_comb
    begin
        ax = s1_x_reg[8] ? ($unsigned(~s1_x_reg) + 9'd1) : $unsigned(s1_x_reg);
        ay = s1_y_reg[7] ? ($unsigned(~s1_y_reg) + 8'd1) : $unsigned(s1_y_reg);
        s2_num_x_next = {ax, {PROJ_SHIFT{1'b0}}};
        s2_num_y_next = {1'b0, ay, {PROJ_SHIFT{1'b0}}};

        // streak depth: z + 2*speed, clamped
        pz_sum     = {1'b0, s1_z_reg} + {3'b000, speed_reg, 1'b0};
        s2_pz_next = (pz_sum > 10'(DEPTH_MAX)) ? 9'(DEPTH_MAX) : pz_sum[8:0];

        z_ext      = {2'b00, s1_z_reg};
        thr_streak = 11'(speed_reg * STREAK_MUL);
        thr_pixel  = 11'(speed_reg * PIXEL_MUL);
        thr_box    = 11'(speed_reg * BOX_MUL);

        // halving truncates toward zero: bias negatives by one
        gray_diff = $signed(10'(GRAY_BASE)) - $signed({1'b0, s1_z_reg});
        gray_adj  = gray_diff + $signed({9'b0, gray_diff[9]});

        s2_side_next.next_x    = s1_x_reg;
        s2_side_next.next_y    = s1_y_reg;
        s2_side_next.next_z    = s1_z_reg;
        s2_side_next.x_neg     = s1_x_reg[8];
        s2_side_next.y_neg     = s1_y_reg[7];
        s2_side_next.streak_ok = (z_ext < thr_streak);
        s2_side_next.gray      = gray_diff[7:0];
        s2_side_next.sgray     = gray_adj[7:1];
        priority if (z_ext > thr_pixel)
            s2_side_next.shape = SHAPE_PIXEL;
        else if (z_ext > thr_box)
            s2_side_next.shape = SHAPE_BOX;
        else
            s2_side_next.shape = SHAPE_CIRCLE;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s2_num_x_reg <= s2_num_x_next;
            s2_num_y_reg <= s2_num_y_next;
            s2_pz_reg    <= s2_pz_next;
            s2_side_reg  <= s2_side_next;
        end
    end

    sfss_div_pipe #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_x (
        .clk      (clk),
        .stage_en (stage_en[DIV_FIRST +: DIV_NUM_W]),
        .num      (s2_num_x_reg),
        .den      (s2_side_reg.next_z),
        .quo      (q_x)
    );

    sfss_div_pipe #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_y (
        .clk      (clk),
        .stage_en (stage_en[DIV_FIRST +: DIV_NUM_W]),
        .num      (s2_num_y_reg),
        .den      (s2_side_reg.next_z),
        .quo      (q_y)
    );

    sfss_div_pipe #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_px (
        .clk      (clk),
        .stage_en (stage_en[DIV_FIRST +: DIV_NUM_W]),
        .num      (s2_num_x_reg),
        .den      (s2_pz_reg),
        .quo      (q_px)
    );

    sfss_div_pipe #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_py (
        .clk      (clk),
        .stage_en (stage_en[DIV_FIRST +: DIV_NUM_W]),
        .num      (s2_num_y_reg),
        .den      (s2_pz_reg),
        .quo      (q_py)
    );

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_NUM_W; k++)
        begin
            if (stage_en[DIV_FIRST + k])
            begin
                if (k == 0)
                    side_reg[k] <= s2_side_reg;
                else
                    side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign side_last = side_reg[DIV_NUM_W-1];

    always_comb
    begin
        sx = place(q_x,  side_last.x_neg, MID_COL);
        sy = place(q_y,  side_last.y_neg, MID_ROW);
        px = place(q_px, side_last.x_neg, MID_COL);
        py = place(q_py, side_last.y_neg, MID_ROW);

        vis        = on_axis(sx, SCREEN_WIDTH) && on_axis(sy, SCREEN_HEIGHT);
        streak_hit = vis && side_last.streak_ok &&
                     on_axis(px, SCREEN_WIDTH) && on_axis(py, SCREEN_HEIGHT);

        out_next.next_x      = side_last.next_x;
        out_next.next_y      = side_last.next_y;
        out_next.next_z      = side_last.next_z;
        out_next.visible     = vis;
        out_next.plot_x      = vis ? sx[8:0] : '0;
        out_next.plot_y      = vis ? sy[7:0] : '0;
        out_next.gray        = vis ? side_last.gray : '0;
        out_next.mark_shape  = vis ? side_last.shape : '0;
        out_next.streak      = streak_hit;
        out_next.streak_x    = streak_hit ? px[8:0] : '0;
        out_next.streak_y    = streak_hit ? py[7:0] : '0;
        out_next.streak_gray = streak_hit ? side_last.sgray : '0;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[OUT_STG])
            out_reg <= out_next;
    end

    assign out_valid = valid_reg[OUT_STG];
    assign out_data  = out_reg;

    // back-pressure only when every stage is full and the sink stalls
    `SFSS_ASSERT_IMP(a_full_stall, !in_ready, (&valid_reg) && !out_ready)
    `SFSS_ASSERT_IMP(a_drain_opens, out_valid && out_ready, in_ready)
    `SFSS_ASSERT_IMP(a_div_nonzero, valid_reg[1], (s2_pz_reg != '0) && (s2_side_reg.next_z != '0))
    `SFSS_ASSERT_NXT(a_take_lands, in_valid && in_ready, valid_reg[0] && (s1_z_reg != '0))

endmodule

// ----- design/sfss_div_pipe.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
module sfss_div_pipe #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 9
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] stage_en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [NUM_W-1:0] dq_reg  [NUM_W];

    logic [DEN_W-1:0] rem_in   [NUM_W];
    logic [DEN_W-1:0] den_in   [NUM_W];
    logic [NUM_W-1:0] dq_in    [NUM_W];
    logic [DEN_W:0]   trial    [NUM_W];
    logic [DEN_W:0]   sub      [NUM_W];
    logic             ge       [NUM_W];
    logic [DEN_W-1:0] rem_next [NUM_W];
    logic [NUM_W-1:0] dq_next  [NUM_W];

    // dq holds the unused dividend bits on top and the quotient bits below
    always_comb
    begin
        for (int k = 0; k < NUM_W; k++)
        begin
            if (k == 0)
            begin
                rem_in[k] = '0;
                den_in[k] = den;
                dq_in[k]  = num;
            end
            else
            begin
                rem_in[k] = rem_reg[k-1];
                den_in[k] = den_reg[k-1];
                dq_in[k]  = dq_reg[k-1];
            end
            trial[k]    = {rem_in[k], dq_in[k][NUM_W-1]};
            sub[k]      = trial[k] - {1'b0, den_in[k]};
            ge[k]       = (trial[k] >= {1'b0, den_in[k]});
            rem_next[k] = ge[k] ? sub[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
            dq_next[k]  = {dq_in[k][NUM_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_W; k++)
        begin
            if (stage_en[k])
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_in[k];
                dq_reg[k]  <= dq_next[k];
            end
        end
    end

    assign quo = dq_reg[NUM_W-1];

endmodule
